[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bsm assertion failed");

// Property checked at every clock edge, reset included.
`define BSM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsm assertion failed");

`endif

[hw/rtl/bsm_pkg.sv]
`timescale 1ns / 1ps

package bsm_pkg;

  // Default number formats.
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Codes reported on merge_case.
  localparam logic [1:0] CASE_SECOND_ENCLOSES = 2'd0;
  localparam logic [1:0] CASE_FIRST_ENCLOSES  = 2'd1;
  localparam logic [1:0] CASE_NEW_SPHERE      = 2'd2;

endpackage

[hw/rtl/bsm_in_if.sv]
`timescale 1ns / 1ps

// Channel carrying one pair of spheres.
interface bsm_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_center_x;
  logic signed [W-1:0] first_center_y;
  logic signed [W-1:0] first_center_z;
  logic        [W-2:0] first_radius;
  logic signed [W-1:0] second_center_x;
  logic signed [W-1:0] second_center_y;
  logic signed [W-1:0] second_center_z;
  logic        [W-2:0] second_radius;

  modport source (
    output valid, first_center_x, first_center_y, first_center_z, first_radius,
    output second_center_x, second_center_y, second_center_z, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_center_x, first_center_y, first_center_z, first_radius,
    input  second_center_x, second_center_y, second_center_z, second_radius,
    output ready
  );
endinterface

[hw/rtl/bsm_out_if.sv]
`timescale 1ns / 1ps

// Channel carrying one enclosing sphere.
interface bsm_out_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] merged_center_x;
  logic signed [W-1:0] merged_center_y;
  logic signed [W-1:0] merged_center_z;
  logic        [W-2:0] merged_radius;
  logic        [1:0]   merge_case;

  modport source (
    output valid, merged_center_x, merged_center_y, merged_center_z,
    output merged_radius, merge_case,
    input  ready
  );
  modport sink (
    input  valid, merged_center_x, merged_center_y, merged_center_z,
    input  merged_radius, merge_case,
    output ready
  );
endinterface

[hw/rtl/bsm_sqrt.sv]
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage.
module bsm_sqrt #(
  parameter  int VW = 68,
  parameter  int SW = 1,
  localparam int RW = VW / 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_value,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  logic [VW-1:0] rem  [0:RW];
  logic [RW-1:0] root [0:RW];
  logic [SW-1:0] side [0:RW];
  logic [RW:0]   vld;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= in_value;
      root[0] <= '0;
      side[0] <= in_side;
    end
  end

  // One stage per root bit, most significant first.
  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;
    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] rem_next;
    logic [RW-1:0] root_next;

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
    always_comb begin
      trial     = ((VW + 1)'(root[s]) << (B + 1)) + ((VW + 1)'(1) << (2 * B));
      fits      = {1'b0, rem[s]} >= trial;
      rem_next  = fits ? (rem[s] - trial[VW-1:0]) : rem[s];
      root_next = fits ? (root[s] | (RW'(1) << B)) : root[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= rem_next;
        root[s+1] <= root_next;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule

[hw/rtl/bsm_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider, several lanes sharing one divisor.
// The quotient must fit in QW bits, so the top DW dividend bits lie below the divisor.
module bsm_div #(
  parameter  int NW    = 68,
  parameter  int DW    = 35,
  parameter  int LANES = 3,
  parameter  int SW    = 1,
  localparam int QW    = NW - DW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   out_quot,
  output logic [SW-1:0]              out_side
);

  logic [LANES-1:0][DW-1:0] rem  [0:QW];
  logic [LANES-1:0][QW-1:0] low  [0:QW];
  logic [LANES-1:0][QW-1:0] quot [0:QW];
  logic [DW-1:0]            den  [0:QW];
  logic [SW-1:0]            side [0:QW];
  logic [QW:0]              vld;

  // Input register: split each dividend into the partial remainder and the bits to come.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l]  <= in_num[l][NW-1:QW];
        low[0][l]  <= in_num[l][QW-1:0];
        quot[0][l] <= '0;
      end
      den[0]  <= in_den;
      side[0] <= in_side;
    end
  end

  // One quotient bit per stage.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quot_next;
    logic [DW:0]              part;
    logic                     fits;

    always_comb begin
      rem_next  = rem[s];
      quot_next = quot[s];
      part      = '0;
      fits      = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        part         = {rem[s][l], low[s][l][QW-1]};
        fits         = part >= {1'b0, den[s]};
        rem_next[l]  = fits ? DW'(part - {1'b0, den[s]}) : part[DW-1:0];
        quot_next[l] = {quot[s][l][QW-2:0], fits};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= rem_next;
        quot[s+1] <= quot_next;
        for (int l = 0; l < LANES; l++) begin
          low[s+1][l] <= {low[s][l][QW-2:0], 1'b0};
        end
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quot  = quot[QW];
  assign out_side  = side[QW];

endmodule

[hw/rtl/bounding_sphere_merge.sv]
`timescale 1ns / 1ps
// Stages: input, squares, distance, square root, product register, divider, output.
// Throughput: one sphere pair per cycle while the output is not stalled; the square
// root and the divider are fully pipelined, one result bit per stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; no clearing pass is needed.
module bounding_sphere_merge #(
  parameter int COORD_WIDTH   = bsm_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = bsm_pkg::FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bsm_in_if.sink   sphere_in,
  bsm_out_if.source sphere_out
);
  import bsm_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int MAG_W  = W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int LSQ_W  = SQ_W + 2;
  localparam int LEN_W  = LSQ_W / 2;
  localparam int RDSQ_W = 2 * (W - 1);
  localparam int NUM_W  = W + 3;
  localparam int PROD_W = MAG_W + NUM_W;
  localparam int DEN_W  = LEN_W + 1;
  localparam int Q_W    = PROD_W - DEN_W;
  localparam int TOL    = (1 << FRACTION_BITS) / 1000000;

  typedef struct packed {
    logic [2:0][W-1:0]     base;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [W-1:0]          rdiff;
    logic [W-1:0]          rsum;
    logic [W-2:0]          encl_r;
    logic                  encl;
    logic [1:0]            mcase;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][W-1:0] base;
    logic [2:0]        neg;
    logic              use_new;
    logic [W-2:0]      rad;
    logic [1:0]        mcase;
  } dv_side_t;

  // Whole pipeline moves when the output register is free.
  logic en;
  assign en              = !sphere_out.valid || sphere_out.ready;
  assign sphere_in.ready = en;

  // Stage 1: input register.
  logic                       s1_valid;
  logic [2:0][W-1:0]          s1_c0;
  logic [2:0][W-1:0]          s1_c1;
  logic [W-2:0]               s1_r0;
  logic [W-2:0]               s1_r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sphere_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c0 <= {sphere_in.first_center_z, sphere_in.first_center_y,
                sphere_in.first_center_x};
      s1_c1 <= {sphere_in.second_center_z, sphere_in.second_center_y,
                sphere_in.second_center_x};
      s1_r0 <= sphere_in.first_radius;
      s1_r1 <= sphere_in.second_radius;
    end
  end

  // Centre differences and radius difference, as magnitude and sign.
  logic [2:0][MAG_W-1:0] s1_mag;
  logic [2:0]            s1_neg;
  logic signed [W-1:0]   s1_rdiff;
  logic [W-2:0]          s1_rdmag;

  always_comb begin
    logic signed [MAG_W-1:0] d;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d         = $signed({s1_c1[k][W-1], s1_c1[k]}) - $signed({s1_c0[k][W-1], s1_c0[k]});
      s1_neg[k] = d[MAG_W-1];
      s1_mag[k] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    end
    s1_rdiff = $signed({1'b0, s1_r1}) - $signed({1'b0, s1_r0});
    s1_rdmag = s1_rdiff[W-1] ? (W-1)'(-s1_rdiff) : s1_rdiff[W-2:0];
  end

  // Stage 2: squares.
  logic                  s2_valid;
  logic [2:0][W-1:0]     s2_c0;
  logic [2:0][W-1:0]     s2_c1;
  logic [W-2:0]          s2_r0;
  logic [W-2:0]          s2_r1;
  logic [2:0][MAG_W-1:0] s2_mag;
  logic [2:0]            s2_neg;
  logic signed [W-1:0]   s2_rdiff;
  logic [W-2:0]          s2_rdmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c0    <= s1_c0;
      s2_c1    <= s1_c1;
      s2_r0    <= s1_r0;
      s2_r1    <= s1_r1;
      s2_mag   <= s1_mag;
      s2_neg   <= s1_neg;
      s2_rdiff <= s1_rdiff;
      s2_rdmag <= s1_rdmag;
    end
  end

  logic [2:0][SQ_W-1:0] s2_sq;
  logic [RDSQ_W-1:0]    s2_rdsq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_sq[k] = s2_mag[k] * s2_mag[k];
    end
    s2_rdsq = s2_rdmag * s2_rdmag;
  end

  // Stage 3: squared distance and enclosure test.
  logic                  s3_valid;
  logic [2:0][W-1:0]     s3_c0;
  logic [2:0][W-1:0]     s3_c1;
  logic [W-2:0]          s3_r0;
  logic [W-2:0]          s3_r1;
  logic [2:0][MAG_W-1:0] s3_mag;
  logic [2:0]            s3_neg;
  logic signed [W-1:0]   s3_rdiff;
  logic [2:0][SQ_W-1:0]  s3_sq;
  logic [RDSQ_W-1:0]     s3_rdsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c0    <= s2_c0;
      s3_c1    <= s2_c1;
      s3_r0    <= s2_r0;
      s3_r1    <= s2_r1;
      s3_mag   <= s2_mag;
      s3_neg   <= s2_neg;
      s3_rdiff <= s2_rdiff;
      s3_sq    <= s2_sq;
      s3_rdsq  <= s2_rdsq;
    end
  end

  logic [LSQ_W-1:0] s3_lsq;
  sq_side_t         s3_side;

  always_comb begin
    logic second;
    s3_lsq = LSQ_W'(s3_sq[0]) + LSQ_W'(s3_sq[1]) + LSQ_W'(s3_sq[2]);
    second = !s3_rdiff[W-1];
    s3_side.encl   = LSQ_W'(s3_rdsq) >= s3_lsq;
    s3_side.mag    = s3_mag;
    s3_side.neg    = s3_neg;
    s3_side.rdiff  = s3_rdiff;
    s3_side.rsum   = W'({1'b0, s3_r0}) + W'({1'b0, s3_r1});
    s3_side.encl_r = second ? s3_r1 : s3_r0;
    if (!s3_side.encl) begin
      s3_side.base  = s3_c0;
      s3_side.mcase = CASE_NEW_SPHERE;
    end else if (second) begin
      s3_side.base  = s3_c1;
      s3_side.mcase = CASE_SECOND_ENCLOSES;
    end else begin
      s3_side.base  = s3_c0;
      s3_side.mcase = CASE_FIRST_ENCLOSES;
    end
  end

  // Centre distance.
  logic             sq_valid;
  logic [LEN_W-1:0] sq_len;
  sq_side_t         sq_side;

  bsm_sqrt #(
    .VW (LSQ_W),
    .SW ($bits(sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_value  (s3_lsq),
    .in_side   (s3_side),
    .out_valid (sq_valid),
    .out_root  (sq_len),
    .out_side  (sq_side)
  );

  // Offset numerators, divisor and radius.
  logic [2:0][PROD_W-1:0] pr_prod;
  logic [DEN_W-1:0]       pr_den;
  dv_side_t               pr_side;

  always_comb begin
    logic signed [NUM_W-1:0] s;
    logic [NUM_W-1:0]        num;
    logic [LEN_W:0]          rad_sum;
    logic [LEN_W-1:0]        rad;
    s       = $signed({1'b0, sq_len}) + NUM_W'($signed(sq_side.rdiff));
    num     = s[NUM_W-1] ? '0 : NUM_W'(s);
    for (int k = 0; k < 3; k++) begin
      pr_prod[k] = sq_side.mag[k] * num;
    end
    pr_den  = {sq_len, 1'b0};
    rad_sum = (LEN_W + 1)'(sq_len) + (LEN_W + 1)'(sq_side.rsum);
    rad     = rad_sum[LEN_W:1];
    pr_side.base    = sq_side.base;
    pr_side.neg     = sq_side.neg;
    pr_side.mcase   = sq_side.mcase;
    pr_side.use_new = !sq_side.encl && (sq_len > LEN_W'(TOL));
    if (sq_side.encl) begin
      pr_side.rad = sq_side.encl_r;
    end else if (rad > LEN_W'({(W-1){1'b1}})) begin
      pr_side.rad = '1;
    end else begin
      pr_side.rad = rad[W-2:0];
    end
  end

  logic                   p_valid;
  logic [2:0][PROD_W-1:0] p_prod;
  logic [DEN_W-1:0]       p_den;
  dv_side_t               p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= pr_prod;
      p_den  <= pr_den;
      p_side <= pr_side;
    end
  end

  // Centre offsets.
  logic                 dv_valid;
  logic [2:0][Q_W-1:0]  dv_off;
  dv_side_t             dv_side;

  bsm_div #(
    .NW    (PROD_W),
    .DW    (DEN_W),
    .LANES (3),
    .SW    ($bits(dv_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_num    (p_prod),
    .in_den    (p_den),
    .in_side   (p_side),
    .out_valid (dv_valid),
    .out_quot  (dv_off),
    .out_side  (dv_side)
  );

  // New centre, saturated to the coordinate range; the base centre when no new sphere is used.
  logic [2:0][W-1:0] fin_c;

  always_comb begin
    logic signed [W+1:0] c;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      if (dv_side.neg[k]) begin
        c = $signed((W + 2)'($signed(dv_side.base[k]))) - $signed({1'b0, dv_off[k]});
      end else begin
        c = $signed((W + 2)'($signed(dv_side.base[k]))) + $signed({1'b0, dv_off[k]});
      end
      if (!dv_side.use_new) begin
        fin_c[k] = dv_side.base[k];
      end else if (c > $signed((W + 2)'({1'b0, {(W-1){1'b1}}}))) begin
        fin_c[k] = {1'b0, {(W-1){1'b1}}};
      end else if (c < -$signed((W + 2)'({1'b1, {(W-1){1'b0}}}))) begin
        fin_c[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        fin_c[k] = c[W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_out.valid <= 1'b0;
    end else if (en) begin
      sphere_out.valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sphere_out.merged_center_x <= fin_c[0];
      sphere_out.merged_center_y <= fin_c[1];
      sphere_out.merged_center_z <= fin_c[2];
      sphere_out.merged_radius   <= dv_side.rad;
      sphere_out.merge_case      <= dv_side.mcase;
    end
  end

endmodule

[hw/rtl/bsm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the sphere merge block.
module bsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] merge_case
);
  import bsm_pkg::*;

  // The input side is held exactly when a result waits unclaimed.
  `BSM_ASSERT(a_ready_follows_output, in_ready == (!out_valid || out_ready))

  // Reset empties the output register.
  `BSM_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid)

  // Only defined case codes leave the block.
  `BSM_ASSERT(a_case_defined, out_valid |-> merge_case <= CASE_NEW_SPHERE)

  // A stalled transaction stays offered.
  `BSM_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid && $stable(merge_case))

  // An idle input with an empty output register leaves ready high.
  `BSM_ASSERT(a_idle_ready, !in_valid && !out_valid |-> in_ready)

endmodule

bind bounding_sphere_merge bsm_checker u_bsm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sphere_in.valid),
  .in_ready   (sphere_in.ready),
  .out_valid  (sphere_out.valid),
  .out_ready  (sphere_out.ready),
  .merge_case (sphere_out.merge_case)
);
